// ----- src/hpg_pkg.sv -----
// Shared types and constants of the Halton point generator.
// Used by hpg_digit_div and halton_point_generator; depends on nothing else.
package hpg_pkg;

   localparam int IDX_W      = 31;
   localparam int FRAC_W     = 32;
   localparam int BASE_W     = 8;
   localparam int WORK_W     = 32;
   localparam int ACC_W      = 39;
   localparam int DIV_STEPS  = 8;
   localparam int DIV_CYCLES = WORK_W / DIV_STEPS;
   localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);
   localparam int FRAC_CNT_W = $clog2(FRAC_W);
   localparam int CSR_IDX_W  = 1;

   localparam logic [BASE_W-1:0] MIN_BASE     = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_X_RESET = BASE_W'(2);
   localparam logic [BASE_W-1:0] BASE_Y_RESET = BASE_W'(3);

   localparam logic [CSR_IDX_W-1:0] CSR_BASE_X = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_BASE_Y = CSR_IDX_W'(1);

   typedef struct packed {
      logic [WORK_W-1:0] work;
      logic [BASE_W-1:0] rem;
   } div_state_type;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_DIV  = 5'b00010,
      ST_ACC  = 5'b00100,
      ST_FRAC = 5'b01000,
      ST_DONE = 5'b10000
   } state_type;

endpackage

// ----- src/hpg_digit_div.sv -----
// Eight steps of restoring division of the working index by the current base.
// Depends on hpg_pkg for widths and the divider state type.
module hpg_digit_div (
   input  hpg_pkg::div_state_type        cur_i,
   input  logic [hpg_pkg::BASE_W-1:0]    base_i,
   output hpg_pkg::div_state_type        next_o
);

   always_comb begin
      logic [hpg_pkg::BASE_W:0] partial;
      hpg_pkg::div_state_type   st;
      st = cur_i;
      for (int i = 0; i < hpg_pkg::DIV_STEPS; i++) begin
         partial = {st.rem, st.work[hpg_pkg::WORK_W-1]};
         if (partial >= {1'b0, base_i}) begin
            st.rem  = hpg_pkg::BASE_W'(partial - {1'b0, base_i});
            st.work = {st.work[hpg_pkg::WORK_W-2:0], 1'b1};
         end else begin
            st.rem  = partial[hpg_pkg::BASE_W-1:0];
            st.work = {st.work[hpg_pkg::WORK_W-2:0], 1'b0};
         end
      end
      next_o = st;
   end

endmodule

// ----- src/halton_point_generator.sv -----
// Top level of the Halton point generator: sequencer, accumulators and ports.
// Depends on hpg_pkg and hpg_digit_div.
//
// Each accepted word yields one 2D point whose coordinates are the radical
// inverses of the sample index in base_x and base_y, as unsigned 0.32
// fractions rounded down; a base register below two acts as base two. The
// coordinates are computed one after the other by one shared datapath. For
// each digit of the index in its base, the eight-step divider passes over the
// whole working index and then one multiply and add step follows; then the 32
// fraction bits come from one-bit long division. The block takes a new word
// once the previous one has reached the result register, even if that result
// is still waiting.
module halton_point_generator (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [hpg_pkg::IDX_W-1:0]       req_sample_index,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [hpg_pkg::FRAC_W-1:0]      rsp_coord_x,
   output logic [hpg_pkg::FRAC_W-1:0]      rsp_coord_y,
   input  logic                            csr_we,
   input  logic [hpg_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hpg_pkg::BASE_W-1:0]      csr_wdata
);

   hpg_pkg::state_type              state_ff, state_in;
   logic [hpg_pkg::BASE_W-1:0]      base_x_ff, base_y_ff;
   logic [hpg_pkg::BASE_W-1:0]      base_ff, base_in;
   logic [hpg_pkg::IDX_W-1:0]       in_idx_ff, in_idx_in;
   logic                            coord_sel_ff, coord_sel_in;
   hpg_pkg::div_state_type          div_ff, div_in, div_step;
   logic [hpg_pkg::DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic [hpg_pkg::ACC_W-1:0]       num_ff, num_in;
   logic [hpg_pkg::ACC_W-1:0]       den_ff, den_in;
   logic [hpg_pkg::FRAC_W-1:0]      frac_ff, frac_in;
   logic [hpg_pkg::FRAC_CNT_W-1:0]  frac_cnt_ff, frac_cnt_in;
   logic [hpg_pkg::FRAC_W-1:0]      cx_ff, cx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [hpg_pkg::FRAC_W-1:0]      rsp_x_ff, rsp_x_in;
   logic [hpg_pkg::FRAC_W-1:0]      rsp_y_ff, rsp_y_in;

   logic                            start_y;
   logic [hpg_pkg::BASE_W-1:0]      sel_base_raw, start_base;
   logic [hpg_pkg::IDX_W-1:0]       start_idx;
   logic [hpg_pkg::ACC_W+hpg_pkg::BASE_W-1:0] num_prod, den_prod;
   logic [hpg_pkg::ACC_W:0]         frac_shift, frac_diff;
   logic                            frac_ge;
   logic                            frac_last;
   logic                            out_free;

   hpg_digit_div u_digit_div (
      .cur_i  (div_ff),
      .base_i (base_ff),
      .next_o (div_step)
   );

   assign start_y      = (state_ff == hpg_pkg::ST_FRAC);
   assign sel_base_raw = start_y ? base_y_ff : base_x_ff;
   assign start_base   = (sel_base_raw < hpg_pkg::MIN_BASE) ? hpg_pkg::MIN_BASE : sel_base_raw;
   assign start_idx    = start_y ? in_idx_ff : req_sample_index;

   assign num_prod = num_ff * base_ff;
   assign den_prod = den_ff * base_ff;

   assign frac_shift = {num_ff, 1'b0};
   assign frac_ge    = (frac_shift >= {1'b0, den_ff});
   assign frac_diff  = frac_shift - {1'b0, den_ff};
   assign frac_last  = (frac_cnt_ff == hpg_pkg::FRAC_CNT_W'(hpg_pkg::FRAC_W - 1));

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      in_idx_in    = in_idx_ff;
      coord_sel_in = coord_sel_ff;
      div_in       = div_ff;
      div_cnt_in   = div_cnt_ff;
      num_in       = num_ff;
      den_in       = den_ff;
      frac_in      = frac_ff;
      frac_cnt_in  = frac_cnt_ff;
      cx_in        = cx_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      unique case (state_ff)
         hpg_pkg::ST_IDLE: begin
            if (req_valid) begin
               in_idx_in    = req_sample_index;
               coord_sel_in = 1'b0;
               base_in      = start_base;
               div_in.work  = {1'b0, start_idx};
               div_in.rem   = '0;
               div_cnt_in   = '0;
               num_in       = '0;
               den_in       = hpg_pkg::ACC_W'(1);
               frac_in      = '0;
               frac_cnt_in  = '0;
               state_in     = (start_idx == '0) ? hpg_pkg::ST_FRAC : hpg_pkg::ST_DIV;
            end
         end
         hpg_pkg::ST_DIV: begin
            div_in     = div_step;
            div_cnt_in = div_cnt_ff + hpg_pkg::DIV_CNT_W'(1);
            if (div_cnt_ff == hpg_pkg::DIV_CNT_W'(hpg_pkg::DIV_CYCLES - 1)) begin
               state_in = hpg_pkg::ST_ACC;
            end
         end
         hpg_pkg::ST_ACC: begin
            num_in     = num_prod[hpg_pkg::ACC_W-1:0] + hpg_pkg::ACC_W'(div_ff.rem);
            den_in     = den_prod[hpg_pkg::ACC_W-1:0];
            div_in.rem = '0;
            div_cnt_in = '0;
            frac_in    = '0;
            frac_cnt_in = '0;
            state_in   = (div_ff.work == '0) ? hpg_pkg::ST_FRAC : hpg_pkg::ST_DIV;
         end
         hpg_pkg::ST_FRAC: begin
            num_in      = frac_ge ? frac_diff[hpg_pkg::ACC_W-1:0]
                                  : frac_shift[hpg_pkg::ACC_W-1:0];
            frac_in     = {frac_ff[hpg_pkg::FRAC_W-2:0], frac_ge};
            frac_cnt_in = frac_cnt_ff + hpg_pkg::FRAC_CNT_W'(1);
            if (frac_last) begin
               if (!coord_sel_ff) begin
                  cx_in        = {frac_ff[hpg_pkg::FRAC_W-2:0], frac_ge};
                  coord_sel_in = 1'b1;
                  base_in      = start_base;
                  div_in.work  = {1'b0, start_idx};
                  div_in.rem   = '0;
                  div_cnt_in   = '0;
                  num_in       = '0;
                  den_in       = hpg_pkg::ACC_W'(1);
                  frac_in      = '0;
                  frac_cnt_in  = '0;
                  state_in     = (start_idx == '0) ? hpg_pkg::ST_FRAC : hpg_pkg::ST_DIV;
               end else begin
                  state_in = hpg_pkg::ST_DONE;
               end
            end
         end
         hpg_pkg::ST_DONE: begin
            if (out_free) begin
               rsp_x_in     = cx_ff;
               rsp_y_in     = frac_ff;
               rsp_valid_in = 1'b1;
               state_in     = hpg_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hpg_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hpg_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         base_x_ff    <= hpg_pkg::BASE_X_RESET;
         base_y_ff    <= hpg_pkg::BASE_Y_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we && (csr_index == hpg_pkg::CSR_BASE_X)) begin
            base_x_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == hpg_pkg::CSR_BASE_Y)) begin
            base_y_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff      <= base_in;
      in_idx_ff    <= in_idx_in;
      coord_sel_ff <= coord_sel_in;
      div_ff       <= div_in;
      div_cnt_ff   <= div_cnt_in;
      num_ff       <= num_in;
      den_ff       <= den_in;
      frac_ff      <= frac_in;
      frac_cnt_ff  <= frac_cnt_in;
      cx_ff        <= cx_in;
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
   end

   assign req_ready   = (state_ff == hpg_pkg::ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_coord_x = rsp_x_ff;
   assign rsp_coord_y = rsp_y_ff;

`ifndef NO_ASSERTIONS
   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == hpg_pkg::ST_DIV || state_ff == hpg_pkg::ST_FRAC))
      else $error("accepted word did not start digit extraction or fraction division");

   a_frac_below_one: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hpg_pkg::ST_FRAC) |-> (num_ff < den_ff))
      else $error("mirrored digits are not below the base power");

   a_base_legal: assert property (@(posedge clock) disable iff (reset)
      (state_ff == hpg_pkg::ST_DIV) |-> (base_ff >= hpg_pkg::MIN_BASE))
      else $error("divider runs with a base below two");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == hpg_pkg::ST_DONE))
      else $error("result word appeared without a finished point");
`endif

endmodule
